[rtl/fpe_pkg.sv]
// shared types, constants and helpers of the framebuffer pixel expander
package fpe_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int PIXELS_PER_ITEM = 8;

    // run length, large enough for a raw pixel_count
    localparam int CNT_W = 4;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_DEPTH_MODE = '0;

    // depth_mode codes
    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_2BPP  = 3'd1;
    localparam logic [2:0] DEPTH_4BPP  = 3'd2;
    localparam logic [2:0] DEPTH_8BPP  = 3'd3;
    localparam logic [2:0] DEPTH_16BPP = 3'd4;
    localparam logic [2:0] DEPTH_32BPP = 3'd5;
    localparam logic [2:0] DEPTH_RESET = DEPTH_8BPP;

    // opcode values
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [31:0] PURE_WHITE   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        opcode;
        logic [31:0] source_word;
        logic [2:0]  first_pixel;
        logic [3:0]  pixel_count;
        logic [7:0]  outside_mask;
        logic [7:0]  palette_index;
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] argb_pixel;
        logic        last_of_run;
    } pix_item_t;

    // one pixel on its way from the sequencer to the output stage
    typedef struct packed {
        logic        use_palette;
        logic        in_range;
        logic [31:0] direct;
        logic        outside;
        logic        last;
    } fpe_issue_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [23:0]       data;
    } fpe_pal_wr_t;

    // 5-bit channel to 8 bits, top bits replicated into the low ones
    function automatic logic [7:0] widen5(input logic [4:0] c);
        widen5 = {c, c[4:2]};
    endfunction

endpackage

[rtl/fpe_palette.sv]
// palette memory: one write port, one read port with registered data
module fpe_palette
(
    input  logic                        clk,
    input  fpe_pkg::fpe_pal_wr_t        wr,
    input  logic                        rd_en,
    input  logic [fpe_pkg::PAL_AW-1:0]  rd_addr,
    output logic [23:0]                 rd_data
);

    logic [23:0] mem [fpe_pkg::PALETTE_ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read before write: a lookup in the same cycle as a write sees the old entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fpe_sequencer.sv]
// item register and per-pixel sequencer
module fpe_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [2:0]                  depth_mode,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  fpe_pkg::cmd_item_t          cmd,
    output logic                        issue_valid,
    input  logic                        issue_ready,
    output fpe_pkg::fpe_issue_t         issue,
    output logic [fpe_pkg::PAL_AW-1:0]  rd_addr,
    output fpe_pkg::fpe_pal_wr_t        pal_wr
);

    localparam int CW = fpe_pkg::CNT_W;

    logic           busy_reg, busy_next;
    logic [31:0]    word_reg;
    logic [2:0]     pos_reg;
    logic [CW-1:0]  left_reg;
    logic [7:0]     omask_reg;

    logic [CW-1:0]  per_unit;
    logic [CW-1:0]  avail;
    logic [CW-1:0]  run_len;
    logic           cmd_fire;
    logic           load;
    logic           fire;
    logic           last_issue;
    logic [2:0]     sh;
    logic [7:0]     fmask;
    logic [7:0]     pidx;

    // pixels per source unit, zero for unused codes
    always_comb
    begin
        case (depth_mode)
            fpe_pkg::DEPTH_1BPP:  per_unit = CW'(8);
            fpe_pkg::DEPTH_2BPP:  per_unit = CW'(4);
            fpe_pkg::DEPTH_4BPP:  per_unit = CW'(2);
            fpe_pkg::DEPTH_8BPP:  per_unit = CW'(1);
            fpe_pkg::DEPTH_16BPP: per_unit = CW'(1);
            fpe_pkg::DEPTH_32BPP: per_unit = CW'(1);
            default:              per_unit = '0;
        endcase
    end

    always_comb
    begin
        if (CW'(cmd.first_pixel) >= per_unit)
        begin
            avail = '0;
        end
        else
        begin
            avail = per_unit - CW'(cmd.first_pixel);
        end
        run_len = (cmd.pixel_count < avail) ? cmd.pixel_count : avail;
        if (run_len > CW'(fpe_pkg::PIXELS_PER_ITEM))
        begin
            run_len = CW'(fpe_pkg::PIXELS_PER_ITEM);
        end
    end

    assign fire        = busy_reg && issue_ready;
    assign last_issue  = (left_reg == CW'(1));
    assign cmd_ready   = !busy_reg || (fire && last_issue);
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign load        = cmd_fire && (cmd.opcode == fpe_pkg::OP_PIXEL) && (run_len != '0);

    always_comb
    begin
        pal_wr.en   = cmd_fire && (cmd.opcode == fpe_pkg::OP_PALETTE)
                      && ({1'b0, cmd.palette_index} < 9'(fpe_pkg::PALETTE_ENTRIES));
        pal_wr.addr = cmd.palette_index[fpe_pkg::PAL_AW-1:0];
        pal_wr.data = {cmd.red_level[15:8], cmd.green_level[15:8], cmd.blue_level[15:8]};
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (fire && last_issue)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= cmd.source_word;
            pos_reg   <= cmd.first_pixel;
            left_reg  <= run_len;
            omask_reg <= cmd.outside_mask;
        end
        else if (fire)
        begin
            pos_reg   <= pos_reg + 3'd1;
            left_reg  <= left_reg - CW'(1);
            omask_reg <= {1'b0, omask_reg[7:1]};
        end
    end

    // field position inside the byte, msb first
    always_comb
    begin
        case (depth_mode)
            fpe_pkg::DEPTH_1BPP:
            begin
                sh    = ~pos_reg;
                fmask = 8'h01;
            end
            fpe_pkg::DEPTH_2BPP:
            begin
                sh    = {~pos_reg[1:0], 1'b0};
                fmask = 8'h03;
            end
            fpe_pkg::DEPTH_4BPP:
            begin
                sh    = {~pos_reg[0], 2'b00};
                fmask = 8'h0F;
            end
            default:
            begin
                sh    = 3'd0;
                fmask = 8'hFF;
            end
        endcase
        pidx = (word_reg[7:0] >> sh) & fmask;
    end

    assign rd_addr     = pidx[fpe_pkg::PAL_AW-1:0];
    assign issue_valid = busy_reg;

    always_comb
    begin
        issue.use_palette = (depth_mode != fpe_pkg::DEPTH_16BPP)
                            && (depth_mode != fpe_pkg::DEPTH_32BPP);
        issue.in_range    = ({1'b0, pidx} < 9'(fpe_pkg::PALETTE_ENTRIES));
        if (depth_mode == fpe_pkg::DEPTH_16BPP)
        begin
            issue.direct = {8'hFF, fpe_pkg::widen5(word_reg[14:10]),
                            fpe_pkg::widen5(word_reg[9:5]), fpe_pkg::widen5(word_reg[4:0])};
        end
        else
        begin
            issue.direct = word_reg | fpe_pkg::ALPHA_OPAQUE;
        end
        issue.outside = omask_reg[0];
        issue.last    = last_issue;
    end

`ifndef SYNTHESIS
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("active run with no pixels left");

    a_run_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((5'(pos_reg) + 5'(left_reg)) <= 5'd8))
        else $error("run reaches past the source unit");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_issue && !load) |=> !busy_reg)
        else $error("sequencer stays busy after the last pixel");
`endif

endmodule

[rtl/fpe_out_stage.sv]
// lookup stage and output register: forms the argb pixel
module fpe_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 issue_valid,
    output logic                 issue_ready,
    input  fpe_pkg::fpe_issue_t  issue,
    input  logic [23:0]          rd_data,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    output fpe_pkg::pix_item_t   pix
);

    logic                 s1_valid_reg;
    fpe_pkg::fpe_issue_t  s1_reg;
    logic                 out_valid_reg;
    fpe_pkg::pix_item_t   out_reg;

    logic                 take;
    logic [31:0]          px;
    logic [31:0]          px_final;

    assign take        = s1_valid_reg && (!out_valid_reg || pix_ready);
    assign issue_ready = !s1_valid_reg || take;

    always_comb
    begin
        if (!s1_reg.use_palette)
        begin
            px = s1_reg.direct;
        end
        else if (s1_reg.in_range)
        begin
            px = fpe_pkg::ALPHA_OPAQUE | {8'h00, rd_data};
        end
        else
        begin
            px = fpe_pkg::ALPHA_OPAQUE;
        end
        // white outside the region is dropped to zero
        px_final = (s1_reg.outside && (px == fpe_pkg::PURE_WHITE)) ? 32'h0 : px;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue_ready)
            begin
                s1_valid_reg <= issue_valid;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_ready && issue_valid)
        begin
            s1_reg <= issue;
        end
        if (take)
        begin
            out_reg.argb_pixel  <= px_final;
            out_reg.last_of_run <= s1_reg.last;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pix_ready) |-> !issue_ready)
        else $error("lookup stage overwritten while output is stalled");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pix_ready) |=> s1_valid_reg)
        else $error("pixel lost from the lookup stage");
`endif

endmodule

[rtl/framebuffer_pixel_expander.sv]
// top level of the framebuffer pixel expander
//
// turns guest framebuffer source units into 32-bit argb pixels, one pixel per
// item on the pix channel. a palette write item gives no pixels. a pixel item
// yields from one to eight pixels (fewer where the unit holds fewer, none for a
// zero count, unused depth codes or a first pixel beyond the unit), and the cmd
// channel takes the next item in the cycle in which the last pixel of the
// current run enters the pipeline, so consecutive runs follow with no gap.
// the rate is one pixel per cycle while the pix channel does not stall, set by
// the single read port of the palette memory and by the result channel. a pixel
// reaches pix through the sequencer's item register, the lookup stage with the
// palette read, and the output register.
// depth_mode sits at byte address 0 of the apb port, resets to
// 8 bpp and is only to be changed while no run is in progress.
module framebuffer_pixel_expander
(
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpe_pkg::APB_AW-1:0]    paddr,
    input  logic [fpe_pkg::APB_DW-1:0]    pwdata,
    output logic [fpe_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,

    // source items
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  fpe_pkg::cmd_item_t            cmd,

    // pixel items
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output fpe_pkg::pix_item_t            pix
);

    logic [2:0]                  depth_mode_reg;
    logic                        cfg_write;
    logic                        sel_depth;

    logic                        issue_valid;
    logic                        issue_ready;
    fpe_pkg::fpe_issue_t         issue;
    logic [fpe_pkg::PAL_AW-1:0]  rd_addr;
    logic [23:0]                 rd_data;
    fpe_pkg::fpe_pal_wr_t        pal_wr;

    // register decode on the word address
    assign sel_depth = (paddr[fpe_pkg::APB_AW-1:2] == fpe_pkg::REG_DEPTH_MODE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= fpe_pkg::DEPTH_RESET;
        end
        else if (cfg_write && sel_depth)
        begin
            depth_mode_reg <= pwdata[2:0];
        end
    end

    assign prdata = sel_depth ? {{(fpe_pkg::APB_DW-3){1'b0}}, depth_mode_reg} : '0;

    // run sequencer: decodes the run, walks the pixels, drives the palette lookup
    fpe_sequencer u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_mode  (depth_mode_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .issue       (issue),
        .rd_addr     (rd_addr),
        .pal_wr      (pal_wr)
    );

    // palette, read in step with the lookup stage
    fpe_palette u_pal
    (
        .clk     (clk),
        .wr      (pal_wr),
        .rd_en   (issue_valid && issue_ready),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pixel forming and output register
    fpe_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .issue       (issue),
        .rd_data     (rd_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix)
    );

endmodule

[dv/framebuffer_pixel_expander_test.sv]
// self-checking testbench for the framebuffer pixel expander
`timescale 1ns / 1ps

module framebuffer_pixel_expander_test;

    // depth codes the block leaves unused, no pixels come out in these
    localparam logic [2:0] DEPTH_SPARE_6 = 3'd6;
    localparam logic [2:0] DEPTH_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 12;   // three-stage pipe plus slack
    localparam int SQUEEZE_CYCLES    = 300;
    localparam int PHASE_ITEMS       = 30;
    localparam int SPARE_PHASE_ITEMS = 6;
    localparam int PHASE_COUNT       = 10;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_NO_PIXEL,
        ROW_ONE_PIXEL
    } row_kind_t;

    typedef struct packed {
        logic [2:0]          depth;
        fpe_pkg::cmd_item_t  item;
        row_kind_t           kind;
        logic [31:0]         argb;
    } probe_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [fpe_pkg::APB_AW-1:0] paddr;
    logic [fpe_pkg::APB_DW-1:0] pwdata;
    logic [fpe_pkg::APB_DW-1:0] prdata;
    logic        pready;
    logic        cmd_valid;
    logic        cmd_ready;
    fpe_pkg::cmd_item_t cmd;
    logic        pix_valid;
    logic        pix_ready;
    fpe_pkg::pix_item_t pix;

    // shadow copy of the block state
    logic [23:0] shadow_palette [0:fpe_pkg::PALETTE_ENTRIES-1];
    bit          pal_written [0:fpe_pkg::PALETTE_ENTRIES-1];
    int          written_list [$];
    logic [2:0]  shadow_depth;

    // pixels still owed by the block, oldest first
    fpe_pkg::pix_item_t pending_pixels [$];
    fpe_pkg::pix_item_t head;
    probe_t      probes [$];

    int          mismatches = 0;
    int          cycle_count;
    int          send_calm = 0;
    int          take_calm = 0;
    bit          squeeze_go = 1'b0;
    bit          squeeze_done = 1'b0;

    framebuffer_pixel_expander uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // 5-bit channel widened to 8 bits, top bits folded into the bottom
    function automatic logic [7:0] stretch5(input logic [4:0] c);
        logic [7:0] wide;
        wide = {3'b000, c};
        return (wide << 3) | (wide >> 2);
    endfunction

    // palette entry keeps the top byte of each 16-bit level
    function automatic void store_palette(input fpe_pkg::cmd_item_t c);
        shadow_palette[c.palette_index] = {c.red_level[15:8], c.green_level[15:8],
                                           c.blue_level[15:8]};
        if (!pal_written[c.palette_index])
        begin
            pal_written[c.palette_index] = 1'b1;
            written_list.push_back(int'(c.palette_index));
        end
    endfunction

    // works out the pixels that one pixel item gives and queues them
    function automatic void expand_item(input fpe_pkg::cmd_item_t c);
        int          bits;
        int          per;
        int          n;
        int          shift;
        int          idx;
        logic [31:0] px;
        logic [15:0] w;
        fpe_pkg::pix_item_t p;
        case (shadow_depth)
            fpe_pkg::DEPTH_1BPP:  begin bits = 1;  per = 8; end
            fpe_pkg::DEPTH_2BPP:  begin bits = 2;  per = 4; end
            fpe_pkg::DEPTH_4BPP:  begin bits = 4;  per = 2; end
            fpe_pkg::DEPTH_8BPP:  begin bits = 8;  per = 1; end
            fpe_pkg::DEPTH_16BPP: begin bits = 16; per = 1; end
            fpe_pkg::DEPTH_32BPP: begin bits = 32; per = 1; end
            default:              return;
        endcase
        if (int'(c.first_pixel) >= per)
            return;
        n = int'(c.pixel_count);
        if (n > per - int'(c.first_pixel))
            n = per - int'(c.first_pixel);
        if (n > fpe_pkg::PIXELS_PER_ITEM)
            n = fpe_pkg::PIXELS_PER_ITEM;
        w = c.source_word[15:0];
        for (int k = 0; k < n; k++)
        begin
            if (bits <= 8)
            begin
                // msb-first packing inside the low byte
                shift = 8 - (int'(c.first_pixel) + k + 1) * bits;
                idx   = (c.source_word[7:0] >> shift) & ((1 << bits) - 1);
                px    = fpe_pkg::ALPHA_OPAQUE | {8'h00, shadow_palette[idx]};
            end
            else if (bits == 16)
                px = {8'hFF, stretch5(w[14:10]), stretch5(w[9:5]), stretch5(w[4:0])};
            else
                px = c.source_word | fpe_pkg::ALPHA_OPAQUE;
            // white outside the rootless region is blanked
            if (c.outside_mask[k] && px == fpe_pkg::PURE_WHITE)
                px = '0;
            p.argb_pixel  = px;
            p.last_of_run = (k == n - 1);
            pending_pixels.push_back(p);
        end
    endfunction

    // gap length: mostly none or short, a few long, now and then a calm stretch
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // a palette index below lim that has been written, entry 0 as fallback
    function automatic int pick_entry(input int lim);
        int v;
        repeat (16)
        begin
            v = $urandom_range(0, lim - 1);
            if (pal_written[v])
                return v;
        end
        return 0;
    endfunction

    function automatic fpe_pkg::cmd_item_t random_item(input logic [2:0] d);
        fpe_pkg::cmd_item_t c;
        int        bits;
        int        per;
        int        unit_lo;
        c.opcode        = fpe_pkg::OP_PIXEL;
        c.source_word   = $urandom;
        c.first_pixel   = 3'($urandom_range(0, 7));
        c.pixel_count   = 4'($urandom_range(0, 15));
        c.outside_mask  = 8'($urandom);
        c.palette_index = 8'($urandom);
        c.red_level     = 16'($urandom);
        c.green_level   = 16'($urandom);
        c.blue_level    = 16'($urandom);
        if ($urandom_range(0, 99) < 15)
        begin
            // palette write, often into the low entries the small depths use
            c.opcode = fpe_pkg::OP_PALETTE;
            if ($urandom_range(0, 1) == 1)
                c.palette_index = 8'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
            begin
                c.red_level[15:8]   = 8'hFF;
                c.green_level[15:8] = 8'hFF;
                c.blue_level[15:8]  = 8'hFF;
            end
            return c;
        end
        case (d)
            fpe_pkg::DEPTH_1BPP:  begin bits = 1;  per = 8; end
            fpe_pkg::DEPTH_2BPP:  begin bits = 2;  per = 4; end
            fpe_pkg::DEPTH_4BPP:  begin bits = 4;  per = 2; end
            fpe_pkg::DEPTH_8BPP:  begin bits = 8;  per = 1; end
            fpe_pkg::DEPTH_16BPP: begin bits = 16; per = 1; end
            fpe_pkg::DEPTH_32BPP: begin bits = 32; per = 1; end
            default:              return c;
        endcase
        // most runs well formed, the rest keep the raw first and count
        if ($urandom_range(0, 99) >= 20)
        begin
            c.first_pixel = 3'($urandom_range(0, per - 1));
            c.pixel_count = 4'($urandom_range(1, per - int'(c.first_pixel)));
        end
        if (bits == 8)
            c.source_word[7:0] = 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
        else if (bits < 8)
        begin
            // every pixel of the unit points at a written entry
            unit_lo = 0;
            for (int pos = 0; pos < per; pos++)
                unit_lo |= pick_entry(1 << bits) << (8 - (pos + 1) * bits);
            c.source_word[7:0] = 8'(unit_lo);
        end
        else if (bits == 16 && $urandom_range(0, 9) == 0)
            c.source_word[14:0] = 15'h7FFF;
        else if (bits == 32 && $urandom_range(0, 9) == 0)
            c.source_word[23:0] = 24'hFF_FFFF;
        return c;
    endfunction

    function automatic probe_t pal_row(input logic [7:0] idx, input logic [15:0] r,
                                       input logic [15:0] g, input logic [15:0] b);
        probe_t p;
        p.depth              = fpe_pkg::DEPTH_8BPP;
        p.item               = '0;
        p.item.opcode        = fpe_pkg::OP_PALETTE;
        p.item.source_word   = $urandom;
        p.item.palette_index = idx;
        p.item.red_level     = r;
        p.item.green_level   = g;
        p.item.blue_level    = b;
        p.kind               = ROW_NO_PIXEL;
        p.argb               = '0;
        return p;
    endfunction

    function automatic probe_t pix_row(input logic [2:0] d, input logic [31:0] w, input int f,
                                       input int n, input logic [7:0] m,
                                       input row_kind_t kind, input logic [31:0] argb);
        probe_t p;
        p.depth              = d;
        p.item.opcode        = fpe_pkg::OP_PIXEL;
        p.item.source_word   = w;
        p.item.first_pixel   = 3'(f);
        p.item.pixel_count   = 4'(n);
        p.item.outside_mask  = m;
        p.item.palette_index = 8'($urandom);
        p.item.red_level     = 16'($urandom);
        p.item.green_level   = 16'($urandom);
        p.item.blue_level    = 16'($urandom);
        p.kind               = kind;
        p.argb               = argb;
        return p;
    endfunction

    // the first eight phases visit every depth code, the rest pick at random
    function automatic logic [2:0] planned_depth(input int phase);
        case (phase)
            0:       return fpe_pkg::DEPTH_4BPP;
            1:       return fpe_pkg::DEPTH_32BPP;
            2:       return fpe_pkg::DEPTH_1BPP;
            3:       return DEPTH_SPARE_6;
            4:       return fpe_pkg::DEPTH_16BPP;
            5:       return fpe_pkg::DEPTH_2BPP;
            6:       return fpe_pkg::DEPTH_8BPP;
            7:       return DEPTH_SPARE_7;
            default: return 3'($urandom_range(0, 5));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %h, got %h", what, want_v, got_v);
    endtask

    // write depth_mode then read it straight back, psel held across both
    task automatic set_depth(input logic [2:0] d);
        logic [fpe_pkg::APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {fpe_pkg::REG_DEPTH_MODE, 2'b00};
        pwdata  <= {{(fpe_pkg::APB_DW-3){1'b0}}, d};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register taken at this edge, read setup follows
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_depth = d;
        if (readback[2:0] !== d)
            note_mismatch("depth_mode readback", {29'd0, d}, readback);
    endtask

    // present one item and book its expected pixels once it is taken
    task automatic offer_item(input probe_t p);
        int        gap;
        fpe_pkg::pix_item_t one;
        gap = idle_len(send_calm);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= p.item;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (p.item.opcode == fpe_pkg::OP_PALETTE)
            store_palette(p.item);
        else if (p.kind == ROW_ONE_PIXEL)
        begin
            one.argb_pixel  = p.argb;
            one.last_of_run = 1'b1;
            pending_pixels.push_back(one);
        end
        else if (p.kind == ROW_PREDICTED)
            expand_item(p.item);
    endtask

    // let every owed pixel out, then give items without pixels time to clear
    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [2:0] d;
        int         quota;
        int         random_count;
        probe_t     row;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        shadow_depth = fpe_pkg::DEPTH_RESET;
        random_count = 0;

        // palette first, nothing may read an entry before it is written
        probes.push_back(pal_row(8'd0, 16'h1234, 16'h5678, 16'h9ABC));
        probes.push_back(pal_row(8'd1, 16'hFFFF, 16'hFFC0, 16'hFF00));
        probes.push_back(pal_row(8'd2, 16'h00FF, 16'hFF00, 16'h7F7F));
        probes.push_back(pal_row(8'd3, 16'h8001, 16'h4000, 16'h2000));
        probes.push_back(pal_row(8'd255, 16'hFF00, 16'h00FF, 16'h80FF));
        // 8 bpp straight out of reset, upper source bits ignored
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'hFFFF_FF00, 0, 1, 8'h00,
                                 ROW_ONE_PIXEL, 32'hFF12_569A));
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'h0000_00FF, 0, 1, 8'hFF,
                                 ROW_ONE_PIXEL, 32'hFFFF_0080));
        // white entry outside the region
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'h0000_0001, 0, 1, 8'h01,
                                 ROW_ONE_PIXEL, 32'h0000_0000));
        // first pixel beyond the unit, zero count, oversized count
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'h0000_0001, 1, 1, 8'h00,
                                 ROW_NO_PIXEL, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'h0000_0002, 0, 0, 8'h00,
                                 ROW_NO_PIXEL, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_8BPP, 32'h0000_0002, 0, 15, 8'h00,
                                 ROW_ONE_PIXEL, 32'hFF00_FF7F));
        // sub-byte depths, full runs, runs cut at the end of the unit and first pixels beyond it
        probes.push_back(pix_row(fpe_pkg::DEPTH_1BPP, 32'h0000_00A5, 0, 8, 8'hF0,
                                 ROW_PREDICTED, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_1BPP, 32'hFFFF_FF3C, 3, 15, 8'hFF,
                                 ROW_PREDICTED, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_2BPP, 32'h0000_001B, 0, 4, 8'h0A,
                                 ROW_PREDICTED, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_2BPP, 32'h0000_001B, 4, 1, 8'h00,
                                 ROW_NO_PIXEL, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_2BPP, 32'h0000_009C, 2, 9, 8'h03,
                                 ROW_PREDICTED, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_4BPP, 32'h0000_0031, 0, 2, 8'h00,
                                 ROW_PREDICTED, '0));
        probes.push_back(pix_row(fpe_pkg::DEPTH_4BPP, 32'h0000_0021, 2, 1, 8'h00,
                                 ROW_NO_PIXEL, '0));
        // 555 extremes, bit 15 ignored
        probes.push_back(pix_row(fpe_pkg::DEPTH_16BPP, 32'hFFFF_7FFF, 0, 1, 8'h01,
                                 ROW_ONE_PIXEL, 32'h0000_0000));
        probes.push_back(pix_row(fpe_pkg::DEPTH_16BPP, 32'h0000_8000, 0, 1, 8'h00,
                                 ROW_ONE_PIXEL, 32'hFF00_0000));
        probes.push_back(pix_row(fpe_pkg::DEPTH_16BPP, 32'h0000_7FFF, 0, 3, 8'h00,
                                 ROW_ONE_PIXEL, 32'hFFFF_FFFF));
        probes.push_back(pix_row(fpe_pkg::DEPTH_16BPP, 32'h0000_2A5D, 0, 1, 8'h00,
                                 ROW_PREDICTED, '0));
        // 32 bpp, alpha forced before the white test
        probes.push_back(pix_row(fpe_pkg::DEPTH_32BPP, 32'h00FF_FFFF, 0, 1, 8'h01,
                                 ROW_ONE_PIXEL, 32'h0000_0000));
        probes.push_back(pix_row(fpe_pkg::DEPTH_32BPP, 32'h1234_5678, 0, 1, 8'hFF,
                                 ROW_ONE_PIXEL, 32'hFF34_5678));
        // unused depth codes
        probes.push_back(pix_row(DEPTH_SPARE_6, 32'h1234_5678, 0, 1, 8'h00, ROW_NO_PIXEL, '0));
        probes.push_back(pix_row(DEPTH_SPARE_7, 32'h0000_0001, 0, 8, 8'h00, ROW_NO_PIXEL, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, depth changed only with the block drained
        foreach (probes[i])
        begin
            if (probes[i].depth != shadow_depth)
            begin
                settle();
                set_depth(probes[i].depth);
            end
            offer_item(probes[i]);
        end

        // random phases, one depth each
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            d = planned_depth(phase);
            settle();
            set_depth(d);
            quota = (d > fpe_pkg::DEPTH_32BPP) ? SPARE_PHASE_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < quota; i++)
            begin
                row.depth = d;
                row.item  = random_item(d);
                row.kind  = ROW_PREDICTED;
                row.argb  = '0;
                offer_item(row);
                random_count++;
                // starve the output once while items keep coming
                if (random_count == 20)
                    squeeze_go = 1'b1;
            end
        end

        settle();
        if (mismatches == 0)
            $display("framebuffer_pixel_expander: match");
        else
            $display("framebuffer_pixel_expander: mismatch");
        $finish;
    end

    // receiver: ready in bursts with random gaps, and one long hold-off
    initial
    begin
        int run;
        int gap;
        pix_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (squeeze_go && !squeeze_done)
            begin
                pix_ready <= 1'b0;
                for (int held = 0; held < SQUEEZE_CYCLES; held++)
                    @(posedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 12);
                pix_ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = idle_len(take_calm);
                if (gap > 0)
                begin
                    pix_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // every taken pixel against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pending_pixels.size() == 0)
                note_mismatch("pixel with nothing owed", 32'h0, pix.argb_pixel);
            else
            begin
                head = pending_pixels.pop_front();
                if (pix.argb_pixel !== head.argb_pixel)
                    note_mismatch("argb_pixel", head.argb_pixel, pix.argb_pixel);
                if (pix.last_of_run !== head.last_of_run)
                    note_mismatch("last_of_run", {31'd0, head.last_of_run},
                                  {31'd0, pix.last_of_run});
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("framebuffer_pixel_expander: mismatch");
        $finish;
    end

endmodule
